// File: sv/ctcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctcg_pkg;

   // Field and register widths
   localparam int DATA_W      = 32;
   localparam int CFG_LEN_W   = 21;
   localparam int CSR_INDEX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_CHUNK  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACING_RECIPROCAL = 2'd1;

   // Register reset values
   localparam logic [CFG_LEN_W-1:0] SAMPLES_PER_CHUNK_RESET  = 21'd1024;
   localparam logic [DATA_W-1:0]    SPACING_RECIPROCAL_RESET = 32'd65536;

   // Chunk length limits
   localparam int MIN_CHUNK_SAMPLES         = 5;
   localparam int MAX_CHUNK_SAMPLES_DEFAULT = 1048576;

   // Result queue sizing: the final sample of a chunk yields four results, and
   // every sample still in the slope pipeline may need room for four more
   localparam int MAX_RESULTS   = 4;
   localparam int PUSH_CNT_W    = $clog2(MAX_RESULTS + 1);
   localparam int FRONT_STAGES  = 4;
   localparam int QUEUE_DEPTH   = 32;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int STALL_LEVEL   = QUEUE_DEPTH - MAX_RESULTS * (FRONT_STAGES + 1);

   // Saturation
   localparam int SAT_IN_W = 68;
   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

   // One segment: both end samples and both end slopes
   typedef struct packed {
      logic signed [DATA_W-1:0] w;
      logic signed [DATA_W-1:0] w_next;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] z_next;
      logic                     last;
   } seg_type;

   // Segments handed from the slope pipeline to the queue in one cycle
   typedef struct packed {
      logic [PUSH_CNT_W-1:0]        count;
      seg_type [MAX_RESULTS-1:0]    seg;
   } front_out_type;

   // One result beat
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] slope;
      logic signed [DATA_W-1:0] square;
      logic signed [DATA_W-1:0] cube;
      logic signed [DATA_W-1:0] deriv_const;
      logic signed [DATA_W-1:0] deriv_linear;
      logic signed [DATA_W-1:0] deriv_square;
      logic                     last;
   } coef_type;

   // Clamp a wide signed value to the 32-bit signed range
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_IN_W-1:0] v);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &v[SAT_IN_W-1:DATA_W-1];
      hi_zeros = ~|v[SAT_IN_W-1:DATA_W-1];
      if (hi_ones || hi_zeros) begin
         return v[DATA_W-1:0];
      end else if (v[SAT_IN_W-1]) begin
         return DATA_MIN;
      end else begin
         return DATA_MAX;
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/ctcg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ctcg_front #(
   parameter int MAX_CHUNK_SAMPLES = ctcg_pkg::MAX_CHUNK_SAMPLES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_beat,
   input  logic signed [ctcg_pkg::DATA_W-1:0]   in_sample,
   input  logic [ctcg_pkg::CFG_LEN_W-1:0]       chunk_len,
   output ctcg_pkg::front_out_type              push
);
   import ctcg_pkg::*;

   localparam int LEN_CLOG = $clog2(MAX_CHUNK_SAMPLES + 1);
   localparam int LEN_W    = (LEN_CLOG > CFG_LEN_W) ? LEN_CLOG : CFG_LEN_W;
   localparam int POS_W    = $clog2(MAX_CHUNK_SAMPLES);

   // Five-point numerator and its quarter
   localparam int FIVE_W = DATA_W + 5;
   localparam int Q4_W   = FIVE_W - 2;
   localparam int LO_W   = 16;
   localparam int HI_W   = Q4_W - LO_W;
   // Divide by three of the upper part, made non-negative by a multiple of three
   localparam int HU_W     = HI_W + 1;
   localparam int HU_SHIFT = HU_W + 1;
   localparam int QU_W     = 2 * HU_W - HU_SHIFT;
   localparam int QH_W     = QU_W + 1;
   // Divide by three of remainder and lower part
   localparam int T_W     = LO_W + 2;
   localparam int T_SHIFT = T_W + 1;
   localparam int HALF_W  = DATA_W + 2;
   localparam int DIFF_W  = DATA_W + 1;

   localparam logic signed [FIVE_W-1:0] FIVE_BIAS  = 6;
   localparam logic signed [HALF_W-1:0] HALF_ONE   = 1;
   localparam logic [HU_W-1:0]          HU_OFFSET  = HU_W'(3 * (1 << (HI_W - 1)));
   localparam logic [HU_W-1:0]          HU_RECIP   = HU_W'(((1 << HU_SHIFT) + 2) / 3);
   localparam logic [T_W-1:0]           T_RECIP    = T_W'(((1 << T_SHIFT) + 2) / 3);
   localparam logic [QH_W-1:0]          QH_BIAS    = QH_W'(1 << (HI_W - 1));

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_FIRST,
      KIND_HALF,
      KIND_FIVE,
      KIND_FINAL
   } kind_type;

   // Build one segment record
   function automatic seg_type make_seg(input logic signed [DATA_W-1:0] w,
                                        input logic signed [DATA_W-1:0] w_next,
                                        input logic signed [DATA_W-1:0] z,
                                        input logic signed [DATA_W-1:0] z_next,
                                        input logic last);
      seg_type s;
      s.w      = w;
      s.w_next = w_next;
      s.z      = z;
      s.z_next = z_next;
      s.last   = last;
      return s;
   endfunction

   // Window, position and first stage
   logic signed [DATA_W-1:0] win_ff [5];
   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         pos_in;
   kind_type                 kind_in;
   kind_type                 f1_kind_ff;
   logic                     f1_valid_ff;

   logic [LEN_W-1:0] len_ext;
   logic [LEN_W-1:0] n_eff;
   logic             is_final;

   // Classify the incoming sample by its place in the chunk
   always_comb begin
      len_ext = LEN_W'(chunk_len);
      if (len_ext < LEN_W'(MIN_CHUNK_SAMPLES)) begin
         n_eff = LEN_W'(MIN_CHUNK_SAMPLES);
      end else if (len_ext > LEN_W'(MAX_CHUNK_SAMPLES)) begin
         n_eff = LEN_W'(MAX_CHUNK_SAMPLES);
      end else begin
         n_eff = len_ext;
      end
      is_final = LEN_W'(pos_ff) >= (n_eff - LEN_W'(1));
      pos_in   = is_final ? '0 : pos_ff + POS_W'(1);
      if (is_final) begin
         kind_in = KIND_FINAL;
      end else if (pos_ff < POS_W'(2)) begin
         kind_in = KIND_NONE;
      end else if (pos_ff == POS_W'(2)) begin
         kind_in = KIND_FIRST;
      end else if (pos_ff == POS_W'(3)) begin
         kind_in = KIND_HALF;
      end else begin
         kind_in = KIND_FIVE;
      end
   end

   // Shift the window on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            win_ff[i] <= '0;
         end
         pos_ff      <= '0;
         f1_valid_ff <= 1'b0;
         f1_kind_ff  <= KIND_NONE;
      end else begin
         f1_valid_ff <= in_beat;
         if (in_beat) begin
            for (int i = 4; i > 0; i--) begin
               win_ff[i] <= win_ff[i-1];
            end
            win_ff[0]  <= in_sample;
            pos_ff     <= pos_in;
            f1_kind_ff <= kind_in;
         end
      end
   end

   // Stage two: differences and the five-point numerator
   logic                     f1_final;
   logic signed [FIVE_W-1:0] five_num;
   logic signed [FIVE_W-1:0] five_q4;
   logic signed [HALF_W-1:0] half_sum;
   logic signed [HALF_W-1:0] half_q;
   logic signed [DIFF_W-1:0] diff_v;

   always_comb begin
      f1_final = (f1_kind_ff == KIND_FINAL);
      five_num = FIVE_W'(win_ff[4]) - FIVE_W'(win_ff[0])
               + ((FIVE_W'(win_ff[1]) - FIVE_W'(win_ff[3])) <<< 3) + FIVE_BIAS;
      five_q4  = five_num >>> 2;
      if (f1_final) begin
         half_sum = HALF_W'(win_ff[0]) - HALF_W'(win_ff[2]) + HALF_ONE;
         diff_v   = DIFF_W'(win_ff[0]) - DIFF_W'(win_ff[1]);
      end else begin
         half_sum = HALF_W'(win_ff[1]) - HALF_W'(win_ff[3]) + HALF_ONE;
         diff_v   = DIFF_W'(win_ff[1]) - DIFF_W'(win_ff[2]);
      end
      half_q = half_sum >>> 1;
   end

   logic signed [DATA_W-1:0] f2_s_ff [4];
   logic [Q4_W-1:0]          f2_q4_ff;
   logic signed [DATA_W-1:0] f2_half_ff;
   logic signed [DATA_W-1:0] f2_diff_ff;
   kind_type                 f2_kind_ff;
   logic                     f2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
      for (int i = 0; i < 4; i++) begin
         f2_s_ff[i] <= win_ff[i];
      end
      f2_q4_ff   <= Q4_W'(five_q4);
      f2_half_ff <= sat_data(SAT_IN_W'(half_q));
      f2_diff_ff <= sat_data(SAT_IN_W'(diff_v));
      f2_kind_ff <= f1_kind_ff;
   end

   // Stage three: upper part of the divide by three
   logic signed [HI_W-1:0] f2_hi;
   logic [HU_W-1:0]        hu;
   logic [2*HU_W-1:0]      hu_prod;
   logic [QU_W-1:0]        qu;
   logic [HU_W-1:0]        hu_rem;

   always_comb begin
      f2_hi   = f2_q4_ff[Q4_W-1:LO_W];
      hu      = HU_W'(f2_hi) + HU_OFFSET;
      hu_prod = (2*HU_W)'(hu) * (2*HU_W)'(HU_RECIP);
      qu      = hu_prod[2*HU_W-1:HU_SHIFT];
      hu_rem  = hu - (HU_W'(qu) + (HU_W'(qu) << 1));
   end

   logic [QU_W-1:0]          f3_qu_ff;
   logic [1:0]               f3_rh_ff;
   logic [LO_W-1:0]          f3_lo_ff;
   logic signed [DATA_W-1:0] f3_s_ff [4];
   logic signed [DATA_W-1:0] f3_half_ff;
   logic signed [DATA_W-1:0] f3_diff_ff;
   kind_type                 f3_kind_ff;
   logic                     f3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else begin
         f3_valid_ff <= f2_valid_ff;
      end
      f3_qu_ff <= qu;
      f3_rh_ff <= hu_rem[1:0];
      f3_lo_ff <= f2_q4_ff[LO_W-1:0];
      for (int i = 0; i < 4; i++) begin
         f3_s_ff[i] <= f2_s_ff[i];
      end
      f3_half_ff <= f2_half_ff;
      f3_diff_ff <= f2_diff_ff;
      f3_kind_ff <= f2_kind_ff;
   end

   // Stage four: lower part of the divide, then join and saturate
   logic [T_W-1:0]           t_val;
   logic [2*T_W-1:0]         t_prod;
   logic [LO_W-1:0]          ql;
   logic [QH_W-1:0]          qh;
   logic signed [DATA_W-1:0] five_z;

   always_comb begin
      t_val  = {f3_rh_ff, f3_lo_ff};
      t_prod = (2*T_W)'(t_val) * (2*T_W)'(T_RECIP);
      ql     = t_prod[T_SHIFT+LO_W-1:T_SHIFT];
      qh     = QH_W'(f3_qu_ff) - QH_BIAS;
      five_z = sat_data(SAT_IN_W'(signed'({qh, ql})));
   end

   logic signed [DATA_W-1:0] f4_five_ff;
   logic signed [DATA_W-1:0] f4_s_ff [4];
   logic signed [DATA_W-1:0] f4_half_ff;
   logic signed [DATA_W-1:0] f4_diff_ff;
   kind_type                 f4_kind_ff;
   logic                     f4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f4_valid_ff <= 1'b0;
      end else begin
         f4_valid_ff <= f3_valid_ff;
      end
      f4_five_ff <= five_z;
      for (int i = 0; i < 4; i++) begin
         f4_s_ff[i] <= f3_s_ff[i];
      end
      f4_half_ff <= f3_half_ff;
      f4_diff_ff <= f3_diff_ff;
      f4_kind_ff <= f3_kind_ff;
   end

   // Form segments and track the previous slope
   logic signed [DATA_W-1:0] slope_prev_ff;
   logic signed [DATA_W-1:0] slope_prev_in;

   always_comb begin
      push          = '0;
      slope_prev_in = slope_prev_ff;
      if (f4_valid_ff) begin
         unique case (f4_kind_ff)
            KIND_NONE: begin
            end
            KIND_FIRST: begin
               slope_prev_in = f4_diff_ff;
            end
            KIND_HALF: begin
               push.count    = PUSH_CNT_W'(1);
               push.seg[0]   = make_seg(f4_s_ff[3], f4_s_ff[2], slope_prev_ff,
                                        f4_half_ff, 1'b0);
               slope_prev_in = f4_half_ff;
            end
            KIND_FIVE: begin
               push.count    = PUSH_CNT_W'(1);
               push.seg[0]   = make_seg(f4_s_ff[3], f4_s_ff[2], slope_prev_ff,
                                        f4_five_ff, 1'b0);
               slope_prev_in = f4_five_ff;
            end
            KIND_FINAL: begin
               // flush the last four segments of the chunk
               push.count    = PUSH_CNT_W'(MAX_RESULTS);
               push.seg[0]   = make_seg(f4_s_ff[3], f4_s_ff[2], slope_prev_ff,
                                        f4_five_ff, 1'b0);
               push.seg[1]   = make_seg(f4_s_ff[2], f4_s_ff[1], f4_five_ff,
                                        f4_half_ff, 1'b0);
               push.seg[2]   = make_seg(f4_s_ff[1], f4_s_ff[0], f4_half_ff,
                                        f4_diff_ff, 1'b0);
               push.seg[3]   = make_seg(f4_s_ff[0], f4_s_ff[0], f4_diff_ff,
                                        '0, 1'b1);
               slope_prev_in = f4_diff_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_prev_ff <= '0;
      end else begin
         slope_prev_ff <= slope_prev_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/ctcg_coef.sv
`timescale 1ns / 1ps
`default_nettype none

module ctcg_coef (
   input  logic                          clock,
   input  logic                          reset,
   input  ctcg_pkg::seg_type             head,
   input  logic                          head_valid,
   output logic                          pop,
   input  logic [ctcg_pkg::DATA_W-1:0]   spacing_reciprocal,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output ctcg_pkg::coef_type            rsp
);
   import ctcg_pkg::*;

   localparam int D_W = DATA_W + 1;
   localparam int Y_W = DATA_W + 4;
   localparam int P_W = 2 * DATA_W;
   localparam int S_W = P_W + 2;
   localparam int FRAC_W = 16;
   localparam logic signed [S_W-1:0] ROUND_HALF = S_W'(1 << (FRAC_W - 1));

   // Stage control: each stage moves when the one after it has room
   logic a_valid_ff;
   logic b_valid_ff;
   logic rsp_valid_ff;
   logic adv_a;
   logic adv_b;
   logic adv_c;

   always_comb begin
      adv_c = !rsp_valid_ff || !rsp_stall;
      adv_b = !b_valid_ff || adv_c;
      adv_a = !a_valid_ff || adv_b;
      pop   = head_valid && adv_a;
   end

   // Stage A: square and cube terms
   logic signed [D_W-1:0]    d;
   logic signed [Y_W-1:0]    y_sum;
   logic signed [Y_W-1:0]    x_sum;
   logic signed [DATA_W-1:0] y_in;
   logic signed [DATA_W-1:0] x_in;

   always_comb begin
      d     = D_W'(head.w_next) - D_W'(head.w);
      y_sum = Y_W'(d) + (Y_W'(d) <<< 1) - (Y_W'(head.z) <<< 1) - Y_W'(head.z_next);
      x_sum = Y_W'(head.z) + Y_W'(head.z_next) - (Y_W'(d) <<< 1);
      y_in  = head.last ? '0 : sat_data(SAT_IN_W'(y_sum));
      x_in  = head.last ? '0 : sat_data(SAT_IN_W'(x_sum));
   end

   logic signed [DATA_W-1:0] a_w_ff;
   logic signed [DATA_W-1:0] a_z_ff;
   logic signed [DATA_W-1:0] a_y_ff;
   logic signed [DATA_W-1:0] a_x_ff;
   logic                     a_last_ff;

   // Stage B: products with the spacing reciprocal
   logic signed [DATA_W:0]   recip_s;
   logic signed [DATA_W-1:0] b_w_ff;
   logic signed [DATA_W-1:0] b_z_ff;
   logic signed [DATA_W-1:0] b_y_ff;
   logic signed [DATA_W-1:0] b_x_ff;
   logic                     b_last_ff;
   logic signed [P_W-1:0]    b_pz_ff;
   logic signed [P_W-1:0]    b_py_ff;
   logic signed [P_W-1:0]    b_px_ff;

   assign recip_s = signed'({1'b0, spacing_reciprocal});

   // Stage C: scale by one, two and three, round and saturate
   logic signed [S_W-1:0] dc_sum;
   logic signed [S_W-1:0] dl_sum;
   logic signed [S_W-1:0] ds_sum;
   logic signed [S_W-1:0] dc_sh;
   logic signed [S_W-1:0] dl_sh;
   logic signed [S_W-1:0] ds_sh;

   always_comb begin
      dc_sum = S_W'(b_pz_ff) + ROUND_HALF;
      dl_sum = (S_W'(b_py_ff) <<< 1) + ROUND_HALF;
      ds_sum = S_W'(b_px_ff) + (S_W'(b_px_ff) <<< 1) + ROUND_HALF;
      dc_sh  = dc_sum >>> FRAC_W;
      dl_sh  = dl_sum >>> FRAC_W;
      ds_sh  = ds_sum >>> FRAC_W;
   end

   coef_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            a_valid_ff <= pop;
         end
         if (adv_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (adv_c) begin
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   // Advance the payload along with the valid bits
   always_ff @(posedge clock) begin
      if (pop) begin
         a_w_ff    <= head.w;
         a_z_ff    <= head.z;
         a_y_ff    <= y_in;
         a_x_ff    <= x_in;
         a_last_ff <= head.last;
      end
      if (adv_b) begin
         b_w_ff    <= a_w_ff;
         b_z_ff    <= a_z_ff;
         b_y_ff    <= a_y_ff;
         b_x_ff    <= a_x_ff;
         b_last_ff <= a_last_ff;
         b_pz_ff   <= P_W'(a_z_ff) * P_W'(recip_s);
         b_py_ff   <= P_W'(a_y_ff) * P_W'(recip_s);
         b_px_ff   <= P_W'(a_x_ff) * P_W'(recip_s);
      end
      if (adv_c) begin
         rsp_ff.value        <= b_w_ff;
         rsp_ff.slope        <= b_z_ff;
         rsp_ff.square       <= b_y_ff;
         rsp_ff.cube         <= b_x_ff;
         rsp_ff.deriv_const  <= sat_data(SAT_IN_W'(dc_sh));
         rsp_ff.deriv_linear <= sat_data(SAT_IN_W'(dl_sh));
         rsp_ff.deriv_square <= sat_data(SAT_IN_W'(ds_sh));
         rsp_ff.last         <= b_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: sv/cubic_table_coefficient_generator.sv
// Throughput: one sample per cycle while req_stall is low; a chunk's final sample yields four
// beats, one per cycle while rsp_stall is low, queued in a 32-entry segment queue; samples
// stall while more than 12 entries are held. The slope path is a four-stage pipeline feeding
// the queue; the coefficient path after the queue has three stages.
// Reset (synchronous, active high) clears windows, position, queue and pipelines and loads
// samples_per_chunk = 1024 and spacing_reciprocal = 65536.
`timescale 1ns / 1ps
`default_nettype none

module cubic_table_coefficient_generator #(
   parameter int MAX_CHUNK_SAMPLES = ctcg_pkg::MAX_CHUNK_SAMPLES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ctcg_pkg::DATA_W-1:0]    req_sample_value,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ctcg_pkg::DATA_W-1:0]    rsp_value_coef,
   output logic signed [ctcg_pkg::DATA_W-1:0]    rsp_slope_coef,
   output logic signed [ctcg_pkg::DATA_W-1:0]    rsp_square_coef,
   output logic signed [ctcg_pkg::DATA_W-1:0]    rsp_cube_coef,
   output logic signed [ctcg_pkg::DATA_W-1:0]    rsp_deriv_const_coef,
   output logic signed [ctcg_pkg::DATA_W-1:0]    rsp_deriv_linear_coef,
   output logic signed [ctcg_pkg::DATA_W-1:0]    rsp_deriv_square_coef,
   output logic                                  rsp_last_in_chunk,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ctcg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ctcg_pkg::DATA_W-1:0]           csr_data
);
   import ctcg_pkg::*;

   // Configuration registers
   logic [CFG_LEN_W-1:0] samples_per_chunk_ff;
   logic [DATA_W-1:0]    spacing_reciprocal_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_per_chunk_ff  <= SAMPLES_PER_CHUNK_RESET;
         spacing_reciprocal_ff <= SPACING_RECIPROCAL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLES_PER_CHUNK:  samples_per_chunk_ff  <= csr_data[CFG_LEN_W-1:0];
            CSR_SPACING_RECIPROCAL: spacing_reciprocal_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Slope pipeline
   logic          in_beat;
   front_out_type push;

   assign in_beat = req_valid && !req_stall;

   ctcg_front #(
      .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (in_beat),
      .in_sample (req_sample_value),
      .chunk_len (samples_per_chunk_ff),
      .push      (push)
   );

   // Segment queue: up to four writes and one read per cycle
   seg_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wptr_ff;
   logic [QUEUE_PTR_W-1:0] rptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_PTR_W-1:0] wptr_in;
   logic [QUEUE_PTR_W-1:0] rptr_in;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   pop;
   logic                   head_valid;
   seg_type                head;

   always_comb begin
      wptr_in    = wptr_ff + QUEUE_PTR_W'(push.count);
      rptr_in    = rptr_ff + QUEUE_PTR_W'(pop);
      count_in   = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
      head_valid = (count_ff != '0);
      head       = queue_ff[rptr_ff];
   end

   // Hold off samples while the queue could not take a full flush from every
   // sample still in flight
   assign req_stall = (count_ff > QUEUE_CNT_W'(STALL_LEVEL));

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (PUSH_CNT_W'(k) < push.count) begin
            queue_ff[wptr_ff + QUEUE_PTR_W'(k)] <= push.seg[k];
         end
      end
   end

   // Coefficient pipeline
   coef_type rsp;

   ctcg_coef u_coef (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .head_valid         (head_valid),
      .pop                (pop),
      .spacing_reciprocal (spacing_reciprocal_ff),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp                (rsp)
   );

   assign rsp_value_coef        = rsp.value;
   assign rsp_slope_coef        = rsp.slope;
   assign rsp_square_coef       = rsp.square;
   assign rsp_cube_coef         = rsp.cube;
   assign rsp_deriv_const_coef  = rsp.deriv_const;
   assign rsp_deriv_linear_coef = rsp.deriv_linear;
   assign rsp_deriv_square_coef = rsp.deriv_square;
   assign rsp_last_in_chunk     = rsp.last;

   // Queue never takes more segments than it has room for
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      ((QUEUE_CNT_W + 1)'(count_ff) + (QUEUE_CNT_W + 1)'(push.count)
         <= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH)))
      else $error("segment queue overflow");

   // The last segment of a chunk carries no square or cube term
   a_last_flat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_in_chunk) |-> (rsp_square_coef == '0 && rsp_cube_coef == '0))
      else $error("last segment has nonzero square or cube term");

   // Nothing leaves the block right after reset
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && push.count == '0))
      else $error("activity right after reset");

endmodule

`default_nettype wire

// File: test/tb_cubic_table_coefficient_generator.sv
`timescale 1ns / 1ps

module tb_cubic_table_coefficient_generator;

   import ctcg_pkg::*;

   typedef logic signed [DATA_W-1:0] word_type;

   localparam longint WORD_HI        = 64'sh7FFF_FFFF;
   localparam longint WORD_LO        = -WORD_HI - 1;
   localparam int     SETTLE_CYCLES  = 16;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     MAX_REPORTS    = 10;
   localparam int     RANDOM_PHASES  = 10;

   // Indexes past the register list; writes to them must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic     req_valid        = 1'b0;
   logic     req_stall;
   word_type req_sample_value = '0;

   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_value_coef;
   word_type rsp_slope_coef;
   word_type rsp_square_coef;
   word_type rsp_cube_coef;
   word_type rsp_deriv_const_coef;
   word_type rsp_deriv_linear_coef;
   word_type rsp_deriv_square_coef;
   logic     rsp_last_in_chunk;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]      csr_data  = '0;

   cubic_table_coefficient_generator u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_value      (req_sample_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_value_coef        (rsp_value_coef),
      .rsp_slope_coef        (rsp_slope_coef),
      .rsp_square_coef       (rsp_square_coef),
      .rsp_cube_coef         (rsp_cube_coef),
      .rsp_deriv_const_coef  (rsp_deriv_const_coef),
      .rsp_deriv_linear_coef (rsp_deriv_linear_coef),
      .rsp_deriv_square_coef (rsp_deriv_square_coef),
      .rsp_last_in_chunk     (rsp_last_in_chunk),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: register copies, sample and slope windows, chunk position
   logic [CFG_LEN_W-1:0] cfg_chunk_len = SAMPLES_PER_CHUNK_RESET;
   logic [DATA_W-1:0]    cfg_recip     = SPACING_RECIPROCAL_RESET;
   word_type             sample_win [5] = '{default: '0};
   word_type             slope_hist [2] = '{default: '0};
   logic [CFG_LEN_W-1:0] chunk_pos     = '0;

   word_type sample_queue [$];
   coef_type pending_coefs [$];
   word_type walk_level = '0;

   int samples_accepted = 0;
   int beats_checked    = 0;
   int flush_beats      = 0;
   int register_writes  = 0;
   int error_count      = 0;
   int quiet_cycles     = 0;

   // Sender pacing
   int burst_left = 0;
   int gap_left   = 0;
   bit drain_hold = 1'b0;

   // Receiver stall pattern
   int stall_mode = 0;
   int stall_left = 0;
   int stall_tick = 0;

   function automatic word_type clamp_word(input longint v);
      if (v > WORD_HI) return word_type'(WORD_HI);
      if (v < WORD_LO) return word_type'(WORD_LO);
      return word_type'(v);
   endfunction

   // n/2 rounded to nearest, ties toward plus infinity
   function automatic word_type halve_round(input longint n);
      return clamp_word((n + 1) >>> 1);
   endfunction

   // n/12 rounded to nearest, ties toward plus infinity
   function automatic word_type twelfth_round(input longint n);
      longint shifted;
      longint quot;
      shifted = n + 6;
      quot    = shifted / 12;
      if (shifted % 12 < 0) quot = quot - 1;
      return clamp_word(quot);
   endfunction

   function automatic word_type five_point_slope();
      longint num;
      num = longint'(sample_win[4]) - longint'(sample_win[0])
          + 8 * (longint'(sample_win[1]) - longint'(sample_win[3]));
      return twelfth_round(num);
   endfunction

   // round(k * v * r / 2^16), saturated
   function automatic word_type scale_by_recip(input word_type v, input int k);
      logic signed [79:0] prod;
      prod = v;
      prod = prod * $signed({48'b0, cfg_recip});
      prod = prod * k;
      prod = (prod + 32768) >>> 16;
      if (prod > WORD_HI) return word_type'(WORD_HI);
      if (prod < WORD_LO) return word_type'(WORD_LO);
      return prod[DATA_W-1:0];
   endfunction

   function automatic void push_segment(input word_type w, input word_type w_next,
                                        input word_type z, input word_type z_next,
                                        input logic is_last);
      coef_type c;
      longint   d;
      word_type sq;
      word_type cu;
      d  = longint'(w_next) - longint'(w);
      sq = '0;
      cu = '0;
      if (!is_last) begin
         sq = clamp_word(3 * d - 2 * longint'(z) - longint'(z_next));
         cu = clamp_word(longint'(z) + longint'(z_next) - 2 * d);
      end
      c.value        = w;
      c.slope        = z;
      c.square       = sq;
      c.cube         = cu;
      c.deriv_const  = scale_by_recip(z, 1);
      c.deriv_linear = scale_by_recip(sq, 2);
      c.deriv_square = scale_by_recip(cu, 3);
      c.last         = is_last;
      pending_coefs.insert(pending_coefs.size(), c);
   endfunction

   // Advance the predictor by one accepted sample and queue the beats it causes
   function automatic void compute_coefficients(input word_type sample);
      int       eff_len;
      int       pos;
      word_type z_mid;
      word_type z_half;
      word_type z_end;
      word_type z_new;
      eff_len = int'(cfg_chunk_len);
      if (eff_len < MIN_CHUNK_SAMPLES) eff_len = MIN_CHUNK_SAMPLES;
      if (eff_len > MAX_CHUNK_SAMPLES_DEFAULT) eff_len = MAX_CHUNK_SAMPLES_DEFAULT;
      pos = int'(chunk_pos);
      for (int i = 4; i > 0; i--) sample_win[i] = sample_win[i-1];
      sample_win[0] = sample;
      if (pos >= eff_len - 1) begin
         // final sample (or past it after a length change): flush four segments
         z_mid  = five_point_slope();
         z_half = halve_round(longint'(sample_win[0]) - longint'(sample_win[2]));
         z_end  = clamp_word(longint'(sample_win[0]) - longint'(sample_win[1]));
         push_segment(sample_win[3], sample_win[2], slope_hist[0], z_mid, 1'b0);
         push_segment(sample_win[2], sample_win[1], z_mid, z_half, 1'b0);
         push_segment(sample_win[1], sample_win[0], z_half, z_end, 1'b0);
         push_segment(sample_win[0], sample_win[0], z_end, '0, 1'b1);
         slope_hist[1] = z_half;
         slope_hist[0] = z_end;
         chunk_pos     = '0;
      end else begin
         chunk_pos = chunk_pos + 1'b1;
         if (pos >= 2) begin
            if (pos == 2) begin
               z_new = clamp_word(longint'(sample_win[1]) - longint'(sample_win[2]));
            end else if (pos == 3) begin
               z_new = halve_round(longint'(sample_win[1]) - longint'(sample_win[3]));
            end else begin
               z_new = five_point_slope();
            end
            if (pos >= 3) push_segment(sample_win[3], sample_win[2], slope_hist[0], z_new, 1'b0);
            slope_hist[1] = slope_hist[0];
            slope_hist[0] = z_new;
         end
      end
   endfunction

   function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("beat %0d %s mismatch: expected %h, got %h", beats_checked, name, want, got);
      end
   endfunction

   function automatic void check_beat(input coef_type seen);
      coef_type want;
      if (pending_coefs.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("unexpected result beat: value_coef %h slope_coef %h", seen.value, seen.slope);
         return;
      end
      want = pending_coefs.pop_front();
      compare_field("value_coef", want.value, seen.value);
      compare_field("slope_coef", want.slope, seen.slope);
      compare_field("square_coef", want.square, seen.square);
      compare_field("cube_coef", want.cube, seen.cube);
      compare_field("deriv_const_coef", want.deriv_const, seen.deriv_const);
      compare_field("deriv_linear_coef", want.deriv_linear, seen.deriv_linear);
      compare_field("deriv_square_coef", want.deriv_square, seen.deriv_square);
      compare_field("last_in_chunk", DATA_W'(want.last), DATA_W'(seen.last));
      if (want.last) flush_beats++;
      beats_checked++;
   endfunction

   // Mostly smooth table data, with full-range jumps and extremes mixed in
   function automatic word_type next_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         walk_level = walk_level + word_type'($urandom_range(0, 8192)) - 32'sd4096;
      end else if (pick < 70) begin
         walk_level = walk_level + ($signed($urandom()) >>> $urandom_range(1, 8));
      end else if (pick < 85) begin
         walk_level = $urandom();
      end else begin
         case ($urandom_range(0, 4))
            0:       walk_level = 32'sh7FFF_FFFF;
            1:       walk_level = 32'sh8000_0000;
            2:       walk_level = '0;
            3:       walk_level = -32'sd1;
            default: walk_level = 32'sd1;
         endcase
      end
      return walk_level;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SAMPLES_PER_CHUNK:  cfg_chunk_len = data[CFG_LEN_W-1:0];
         CSR_SPACING_RECIPROCAL: cfg_recip     = data;
         default: ;
      endcase
      register_writes++;
   endtask

   // Wait until every sample is in and every beat is out, then let the pipeline empty
   task automatic drain_all();
      while (sample_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_coefs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sample driver: bursts and gaps, occasionally holding off until all beats are back
   always @(posedge clock) begin : sample_driver
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            compute_coefficients(req_sample_value);
            samples_accepted++;
         end
         // hold a stalled beat, otherwise pick the next one
         if (!req_valid || !req_stall) begin
            offer = 1'b0;
            if (drain_hold && pending_coefs.size() == 0) drain_hold = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (!drain_hold && sample_queue.size() != 0) begin
               offer = 1'b1;
            end
            if (offer) begin
               req_sample_value <= sample_queue.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                  if ($urandom_range(0, 30) == 0) drain_hold = 1'b1;
               end
            end
            req_valid <= offer;
         end
      end
   end

   // Result monitor and receiver stall pattern
   always @(posedge clock) begin : result_monitor
      coef_type seen;
      logic     next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.value        = rsp_value_coef;
            seen.slope        = rsp_slope_coef;
            seen.square       = rsp_square_coef;
            seen.cube         = rsp_cube_coef;
            seen.deriv_const  = rsp_deriv_const_coef;
            seen.deriv_linear = rsp_deriv_linear_coef;
            seen.deriv_square = rsp_deriv_square_coef;
            seen.last         = rsp_last_in_chunk;
            check_beat(seen);
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
         end else begin
            stall_left--;
         end
         stall_tick++;
         case (stall_mode)
            0:       next_stall = 1'b0;
            1:       next_stall = ($urandom_range(0, 3) == 0);
            2:       next_stall = ($urandom_range(0, 9) < 6);
            default: next_stall = ((stall_tick % 7) < 3);
         endcase
         rsp_stall <= next_stall;
      end
   end

   // Watchdog: end the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: %0d beats still expected", pending_coefs.size());
         $display("cubic_table_coefficient_generator test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          n_items;
      logic [31:0] len_word;
      logic [31:0] recip_word;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: shortest chunks with extreme, flat and tie-rounding samples
      write_register(CSR_SAMPLES_PER_CHUNK, 32'd5);
      write_register(CSR_SPACING_RECIPROCAL, 32'hFFFF_FFFF);
      sample_queue = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh7FFF_FFFF, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd3};
      drain_all();

      // Random phases; early ones walk through the register extremes and a
      // chunk length cut below the current position
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin len_word = 32'd2097151; recip_word = $urandom(); end
            1: begin len_word = 32'd6;       recip_word = 32'd0; end
            2: begin len_word = 32'd0;       recip_word = 32'd1; end
            3: begin len_word = 32'd1048576; recip_word = 32'd65536; end
            4: begin len_word = 32'd4;       recip_word = 32'hFFFF_FFFF; end
            5: begin len_word = 32'd1024;    recip_word = $urandom_range(1, 32'h0002_0000); end
            default: begin
               len_word = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4)
                                                      : $urandom_range(5, 24);
               case ($urandom_range(0, 3))
                  0:       recip_word = $urandom();
                  1:       recip_word = $urandom_range(1, 32'h0001_0000);
                  2:       recip_word = 32'd0;
                  default: recip_word = 32'hFFFF_FFFF;
               endcase
            end
         endcase
         write_register(CSR_SAMPLES_PER_CHUNK, ($urandom() & 32'hFFE0_0000) | len_word);
         if (phase % 3 == 2) write_register((phase % 2) ? CSR_SPARE_B : CSR_SPARE_A, $urandom());
         write_register(CSR_SPACING_RECIPROCAL, recip_word);
         n_items = $urandom_range(16, 26);
         repeat (n_items) sample_queue.insert(sample_queue.size(), next_sample());
         drain_all();
      end

      $display("ran %0d samples over %0d register writes, chunk lengths 0 to 2097151",
               samples_accepted, register_writes);
      $display("checked %0d coefficient beats, %0d of them chunk-closing", beats_checked,
               flush_beats);
      if (error_count == 0) begin
         $display("cubic_table_coefficient_generator test passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("cubic_table_coefficient_generator test failed");
      end
      $finish;
   end

endmodule
